[src/multi_slot_periodic_timer_assert.svh]
// Assertion macros shared by the timer table modules
`ifndef MULTI_SLOT_PERIODIC_TIMER_ASSERT_SVH
`define MULTI_SLOT_PERIODIC_TIMER_ASSERT_SVH

// same-cycle implication
`define MSPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MSPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/msp_pkg.sv]
package msp_pkg;

    localparam int SLOTS      = 32;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int COUNT_W    = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int STEP_W     = 10;
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;
    localparam int RESULT_CAP = 32;
    localparam int CAP_W      = $clog2(RESULT_CAP + 1);
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 3;
    localparam int SLOT_NUM_W = 5;
    localparam int CMD_DEPTH  = 2;
    localparam int QPTR_W     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(CMD_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATED   = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_DESTROYED = 3'd2,
        KIND_EXPIRED   = 3'd3,
        KIND_IDLE_TICK = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CREATE,
        OP_DESTROY
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [COUNT_W-1:0]    interval;
        logic                  notify;
        logic [SLOT_NUM_W-1:0] slot;
        logic                  slot_ok;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_TICK,
        ST_FINISH,
        ST_REPLY
    } eng_state_t;

endpackage

[src/msp_in_if.sv]
interface msp_in_if
    import msp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [COUNT_W-1:0]    interval_ms;
    logic                  notify;
    logic [SLOT_NUM_W-1:0] slot_id;

    modport source (output valid, output mode, output interval_ms, output notify,
                    output slot_id, input ready);
    modport sink   (input valid, input mode, input interval_ms, input notify,
                    input slot_id, output ready);
endinterface

[src/msp_out_if.sv]
interface msp_out_if
    import msp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [SLOT_NUM_W-1:0] slot_num;
    logic                  last;

    modport source (output valid, output kind, output slot_num, output last, input ready);
    modport sink   (input valid, input kind, input slot_num, input last, output ready);
endinterface

[src/msp_front.sv]
module msp_front
    import msp_pkg::*;
(
    msp_in_if.sink req,
    input  logic   q_full,
    output logic   q_push,
    output cmd_t   q_cmd
);

    logic known;

    assign req.ready = !q_full;

    always_comb
    begin
        known          = 1'b1;
        q_cmd.op       = OP_TICK;
        q_cmd.interval = req.interval_ms;
        q_cmd.notify   = req.notify;
        q_cmd.slot     = req.slot_id;
        q_cmd.slot_ok  = (32'(req.slot_id) < SLOTS);
        case (req.mode)
            MODE_TICK:    q_cmd.op = OP_TICK;
            MODE_CREATE:  q_cmd.op = OP_CREATE;
            MODE_DESTROY: q_cmd.op = OP_DESTROY;
            default:      known = 1'b0;
        endcase
    end

    // drop unknown modes
    assign q_push = req.valid && !q_full && known;

endmodule

[src/msp_cmd_queue.sv]
`include "multi_slot_periodic_timer_assert.svh"

module msp_cmd_queue
    import msp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              entry_reg [CMD_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(CMD_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `MSPT_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)
    `MSPT_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid)
    `MSPT_ASSERT_NEXT(a_fill_tracks, clk, rst_n, push && !pop, cnt_reg != '0)

endmodule

[src/msp_engine.sv]
`include "multi_slot_periodic_timer_assert.svh"

module msp_engine
    import msp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    msp_out_if.source         rsp
);

    eng_state_t            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [SLOTS-1:0]      occ_reg, occ_next;
    logic [SLOTS-1:0]      arm_reg, arm_next;
    logic [STEP_W-1:0]     step_reg;

    logic [COUNT_W-1:0]    period_mem  [SLOTS];
    logic [COUNT_W-1:0]    elapsed_mem [SLOTS];
    logic [COUNT_W-1:0]    rd_period_reg;
    logic [COUNT_W-1:0]    rd_elapsed_reg;

    logic                  b_valid_reg, b_valid_next;
    logic [SLOT_W-1:0]     b_idx_reg;
    logic                  b_act_reg;

    logic                  pend_valid_reg, pend_valid_next;
    logic [SLOT_NUM_W-1:0] pend_slot_reg, pend_slot_next;
    logic [CAP_W-1:0]      res_cnt_reg, res_cnt_next;

    kind_t                 reply_kind_reg, reply_kind_next;
    logic [SLOT_NUM_W-1:0] reply_slot_reg, reply_slot_next;

    logic                  out_valid_reg;
    kind_t                 out_kind_reg;
    logic [SLOT_NUM_W-1:0] out_slot_reg;
    logic                  out_last_reg;

    logic                  out_free;
    logic                  emit;
    kind_t                 emit_kind;
    logic [SLOT_NUM_W-1:0] emit_slot;
    logic                  emit_last;

    logic [SLOT_W-1:0]     cur_slot;
    logic                  cur_free;
    logic                  scan_last;
    logic                  issue_more;
    logic                  rd_en;
    logic [COUNT_W:0]      sum;
    logic [COUNT_W-1:0]    sat;
    logic                  expire;
    logic                  record;
    logic                  stall;
    logic                  b_go;
    logic                  tick_end;

    logic                  per_we;
    logic                  ela_we;
    logic [SLOT_W-1:0]     ela_addr;
    logic [COUNT_W-1:0]    ela_data;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign cur_slot   = idx_reg[SLOT_W-1:0];
    assign cur_free   = !occ_reg[cur_slot];
    assign scan_last  = (idx_reg == CNT_W'(SLOTS - 1));
    assign issue_more = (idx_reg < CNT_W'(SLOTS));

    assign sum    = {1'b0, rd_elapsed_reg} + (COUNT_W + 1)'(step_reg);
    assign sat    = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    assign expire = b_act_reg && (sat >= rd_period_reg);
    assign record = expire && (res_cnt_reg < CAP_W'(RESULT_CAP));
    assign stall  = b_valid_reg && record && pend_valid_reg && !out_free;
    assign b_go   = b_valid_reg && !stall;
    assign rd_en  = (state_reg == ST_TICK) && issue_more && (!b_valid_reg || b_go);
    assign tick_end = !issue_more && (!b_valid_reg || b_go);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        OP_TICK:    state_next = ST_TICK;
                        OP_CREATE:  state_next = ST_CREATE;
                        OP_DESTROY: state_next = ST_REPLY;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CREATE:
            begin
                if (cur_free || scan_last)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_TICK:
            begin
                if (tick_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH, ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        occ_next        = occ_reg;
        arm_next        = arm_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        res_cnt_next    = res_cnt_reg;
        reply_kind_next = reply_kind_reg;
        reply_slot_next = reply_slot_reg;
        b_valid_next    = b_valid_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        emit_kind       = KIND_IDLE_TICK;
        emit_slot       = '0;
        emit_last       = 1'b1;
        per_we          = 1'b0;
        ela_we          = 1'b0;
        ela_addr        = cur_slot;
        ela_data        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    cmd_next     = q_cmd;
                    idx_next     = '0;
                    res_cnt_next = '0;
                    if (q_cmd.op == OP_DESTROY)
                    begin
                        if (q_cmd.slot_ok)
                        begin
                            occ_next[SLOT_W'(q_cmd.slot)] = 1'b0;
                            arm_next[SLOT_W'(q_cmd.slot)] = 1'b0;
                        end
                        reply_kind_next = KIND_DESTROYED;
                        reply_slot_next = q_cmd.slot;
                    end
                end
            end
            ST_CREATE:
            begin
                if (cur_free)
                begin
                    occ_next[cur_slot] = 1'b1;
                    arm_next[cur_slot] = cmd_reg.notify;
                    per_we             = 1'b1;
                    ela_we             = 1'b1;
                    reply_kind_next    = KIND_CREATED;
                    reply_slot_next    = SLOT_NUM_W'(cur_slot);
                end
                else if (scan_last)
                begin
                    reply_kind_next = KIND_FULL;
                    reply_slot_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TICK:
            begin
                if (rd_en)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                b_valid_next = rd_en ? 1'b1 : (b_go ? 1'b0 : b_valid_reg);
                if (b_go)
                begin
                    ela_we   = b_act_reg;
                    ela_addr = b_idx_reg;
                    ela_data = expire ? '0 : sat;
                    if (record)
                    begin
                        // release the held expiry before taking the new one
                        if (pend_valid_reg)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_EXPIRED;
                            emit_slot = pend_slot_reg;
                            emit_last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = SLOT_NUM_W'(b_idx_reg);
                        res_cnt_next    = res_cnt_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_kind       = pend_valid_reg ? KIND_EXPIRED : KIND_IDLE_TICK;
                    emit_slot       = pend_valid_reg ? pend_slot_reg : '0;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_kind = reply_kind_reg;
                    emit_slot = reply_slot_reg;
                    emit_last = 1'b1;
                end
            end
            default:
            begin
                b_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            occ_reg        <= '0;
            arm_reg        <= '0;
            step_reg       <= STEP_RESET;
            b_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            occ_reg        <= occ_next;
            arm_reg        <= arm_next;
            b_valid_reg    <= b_valid_next;
            pend_valid_reg <= pend_valid_next;
            res_cnt_reg    <= res_cnt_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pend_slot_reg  <= pend_slot_next;
        reply_kind_reg <= reply_kind_next;
        reply_slot_reg <= reply_slot_next;
        if (rd_en)
        begin
            b_idx_reg <= cur_slot;
            b_act_reg <= occ_reg[cur_slot] && arm_reg[cur_slot];
        end
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_slot_reg <= emit_slot;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            period_mem[cur_slot] <= cmd_reg.interval;
        end
        if (ela_we)
        begin
            elapsed_mem[ela_addr] <= ela_data;
        end
        if (rd_en)
        begin
            rd_period_reg  <= period_mem[cur_slot];
            rd_elapsed_reg <= elapsed_mem[cur_slot];
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.kind     = out_kind_reg;
    assign rsp.slot_num = out_slot_reg;
    assign rsp.last     = out_last_reg;

    `MSPT_ASSERT_IMPL(a_pend_in_tick, clk, rst_n, pend_valid_reg, (state_reg == ST_TICK) || (state_reg == ST_FINISH))
    `MSPT_ASSERT_IMPL(a_stage_in_tick, clk, rst_n, b_valid_reg, state_reg == ST_TICK)
    `MSPT_ASSERT_IMPL(a_emit_room, clk, rst_n, emit, out_free)
    `MSPT_ASSERT_IMPL(a_result_cap, clk, rst_n, 1'b1, res_cnt_reg <= CAP_W'(RESULT_CAP))

endmodule

[src/multi_slot_periodic_timer.sv]
// Table of 32 periodic timers. Create takes the lowest free slot and answers with its
// number or with table full; destroy frees a slot; tick adds tick_step to every armed
// slot, reports each expiry in slot order with last on the final one, or one idle-tick
// result when nothing expires. Items enter a two-deep command queue, so the input side
// keeps taking items while the table is busy until the queue is full. The table executes
// one item at a time: a create scans upward from slot 0 for the free slot, and a tick
// walks the period and elapsed memories at one slot per cycle unless result
// backpressure stalls the walk.
// Period and elapsed memories need no clearing after reset.
module multi_slot_periodic_timer
    import msp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    msp_in_if.sink            req,
    msp_out_if.source         rsp
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    msp_front u_front (
        .req    (req),
        .q_full (full),
        .q_push (push),
        .q_cmd  (push_cmd)
    );

    msp_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    msp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (head_valid),
        .q_cmd     (head_cmd),
        .q_pop     (pop),
        .rsp       (rsp)
    );

endmodule

[verif/msp_checker.sv]
module msp_checker
    import msp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    msp_in_if                 req,
    msp_out_if                rsp,
    output int                err_count,
    output int                pending,
    output int                accepted,
    output int                result_count,
    output int                expiry_count,
    output int                full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_NUM_W-1:0] slot;
        logic                  last;
    } timer_reply_t;

    timer_reply_t          replies_due[$];
    logic [SLOTS-1:0]      slot_used;
    logic [SLOTS-1:0]      slot_armed;
    logic [COUNT_W-1:0]    slot_period  [SLOTS];
    logic [COUNT_W-1:0]    slot_elapsed [SLOTS];
    logic [STEP_W-1:0]     step_ms;

    function automatic timer_reply_t reply(input kind_t k, input int s, input logic l);
        timer_reply_t r;
        r.kind = k;
        r.slot = s[SLOT_NUM_W-1:0];
        r.last = l;
        return r;
    endfunction

    task automatic run_timer_item(input logic [MODE_W-1:0]     mode,
                                  input logic [COUNT_W-1:0]    interval,
                                  input logic                  notify,
                                  input logic [SLOT_NUM_W-1:0] sid);
        int             free_slot;
        int             i;
        int             fired[$];
        logic [COUNT_W:0] sum;
        free_slot = -1;
        if (mode == MODE_CREATE) begin
            for (i = 0; i < SLOTS; i++) begin
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            end
            if (free_slot < 0) begin
                replies_due.push_back(reply(KIND_FULL, 0, 1'b1));
                full_count++;
            end else begin
                slot_used[free_slot]    = 1'b1;
                slot_armed[free_slot]   = notify;
                slot_period[free_slot]  = interval;
                slot_elapsed[free_slot] = '0;
                replies_due.push_back(reply(KIND_CREATED, free_slot, 1'b1));
            end
        end else if (mode == MODE_DESTROY) begin
            if (int'(sid) < SLOTS) begin
                slot_used[sid]  = 1'b0;
                slot_armed[sid] = 1'b0;
            end
            replies_due.push_back(reply(KIND_DESTROYED, int'(sid), 1'b1));
        end else if (mode == MODE_TICK) begin
            for (i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && slot_armed[i]) begin
                    sum = {1'b0, slot_elapsed[i]} + step_ms;
                    if (sum > {1'b0, COUNT_MAX})
                        sum = {1'b0, COUNT_MAX};
                    if (sum[COUNT_W-1:0] >= slot_period[i]) begin
                        slot_elapsed[i] = '0;
                        if (fired.size() < RESULT_CAP)
                            fired.push_back(i);
                    end else begin
                        slot_elapsed[i] = sum[COUNT_W-1:0];
                    end
                end
            end
            if (fired.size() == 0)
                replies_due.push_back(reply(KIND_IDLE_TICK, 0, 1'b1));
            for (i = 0; i < fired.size(); i++)
                replies_due.push_back(reply(KIND_EXPIRED, fired[i], i == fired.size() - 1));
            expiry_count += fired.size();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        timer_reply_t want;
        if (!rst_n) begin
            replies_due.delete();
            slot_used    = '0;
            slot_armed   = '0;
            step_ms      = STEP_RESET;
            err_count    = 0;
            pending      = 0;
            accepted     = 0;
            result_count = 0;
            expiry_count = 0;
            full_count   = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                result_count++;
                if (replies_due.size() == 0) begin
                    if (err_count < 10)
                        $display("%0t: unexpected result kind %0d slot %0d last %0d",
                                 $time, rsp.kind, rsp.slot_num, rsp.last);
                    err_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (rsp.kind !== want.kind || rsp.slot_num !== want.slot
                        || rsp.last !== want.last) begin
                        if (err_count < 10)
                            $display("%0t: mismatch, expected kind %0d slot %0d last %0d, got kind %0d slot %0d last %0d",
                                     $time, want.kind, want.slot, want.last,
                                     rsp.kind, rsp.slot_num, rsp.last);
                        err_count++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                accepted++;
                run_timer_item(req.mode, req.interval_ms, req.notify, req.slot_id);
            end
            if (cfg_we)
                step_ms = cfg_wdata;
            pending = replies_due.size();
        end
    end

endmodule

[verif/tb_top.sv]
module tb_top
    import msp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 75;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE       = SLOTS + 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    msp_in_if  req_if();
    msp_out_if rsp_if();

    int err_count;
    int pending;
    int accepted;
    int result_count;
    int expiry_count;
    int full_count;

    bit quiet;
    int hold_asked;
    int hold_done;
    logic [STEP_W-1:0] cur_step;

    multi_slot_periodic_timer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    msp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req          (req_if),
        .rsp          (rsp_if),
        .err_count    (err_count),
        .pending      (pending),
        .accepted     (accepted),
        .result_count (result_count),
        .expiry_count (expiry_count),
        .full_count   (full_count)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input logic [MODE_W-1:0]     mode,
                             input logic [COUNT_W-1:0]    interval,
                             input logic                  notify,
                             input logic [SLOT_NUM_W-1:0] sid);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= mode;
        req_if.interval_ms <= interval;
        req_if.notify      <= notify;
        req_if.slot_id     <= sid;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_step   = value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [COUNT_W-1:0] pick_interval(input logic [STEP_W-1:0] step);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return COUNT_MAX;
        if (sel == 2)
            return COUNT_W'($urandom);
        return COUNT_W'($urandom_range(0, 6 * int'(step) + 1));
    endfunction

    task automatic send_random(input int create_pct);
        int roll;
        logic [MODE_W-1:0] mode;
        roll = $urandom_range(0, 99);
        if (roll < create_pct)
            mode = MODE_CREATE;
        else if (roll < create_pct + (97 - create_pct) / 2)
            mode = MODE_TICK;
        else if (roll < 97)
            mode = MODE_DESTROY;
        else
            mode = MODE_UNUSED;
        send_item(mode, pick_interval(cur_step), $urandom_range(0, 99) < 85,
                  SLOT_NUM_W'($urandom_range(0, 31)));
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (hold_asked != hold_done) begin
                gap = HOLD_CYCLES;
                hold_done++;
            end
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid && rsp_if.ready));
            @(negedge clk);
        end
    end

    initial begin
        int p;
        int n;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_TICK;
        req_if.interval_ms = '0;
        req_if.notify      = 1'b0;
        req_if.slot_id     = '0;
        rsp_if.ready       = 1'b0;
        quiet              = 1'b0;
        hold_asked         = 0;
        hold_done          = 0;
        cur_step           = STEP_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(MODE_TICK,    24'd0,        1'b0, 5'd0);
        send_item(MODE_CREATE,  24'd0,        1'b1, 5'h1f);
        send_item(MODE_CREATE,  COUNT_MAX,    1'b1, 5'd0);
        send_item(MODE_CREATE,  24'd25,       1'b0, 5'd0);
        send_item(MODE_CREATE,  24'd20,       1'b1, 5'h15);
        send_item(MODE_TICK,    24'd0,        1'b0, 5'd0);
        send_item(MODE_TICK,    24'hffffff,   1'b1, 5'h1f);
        send_item(MODE_DESTROY, 24'd0,        1'b0, 5'd31);
        send_item(MODE_DESTROY, 24'd0,        1'b0, 5'd2);
        send_item(MODE_UNUSED,  24'habcdef,   1'b1, 5'h0a);
        send_item(MODE_CREATE,  24'd30,       1'b1, 5'd0);
        send_item(MODE_TICK,    24'd0,        1'b0, 5'd0);
        send_item(MODE_DESTROY, 24'd0,        1'b0, 5'd3);
        send_item(MODE_TICK,    24'd0,        1'b0, 5'd0);
        send_item(MODE_CREATE,  24'h555555,   1'b1, 5'h0a);
        send_item(MODE_CREATE,  24'haaaaaa,   1'b0, 5'h15);
        send_item(MODE_DESTROY, 24'hffffff,   1'b1, 5'h10);
        send_item(MODE_TICK,    24'd0,        1'b0, 5'd0);
        send_item(MODE_DESTROY, 24'h123456,   1'b0, 5'd0);
        send_item(MODE_TICK,    24'd0,        1'b0, 5'd0);

        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       write_step(10'd1);
                1:       write_step(10'd1000);
                2:       write_step(10'd1023);
                3:       write_step(10'd0);
                4:       write_step(STEP_RESET);
                default: write_step(STEP_W'($urandom_range(1, 1000)));
            endcase
            if (p == 1)
                hold_asked++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (p == 3 && n < 25);
                send_random(p == 0 ? 60 : 25);
            end
            quiet = 1'b0;
        end

        wait_idle();
        $display("Run covered %0d items and %0d results: %0d expiries, %0d table-full replies,",
                 accepted, result_count, expiry_count, full_count);
        $display("seven tick_step settings including 0 and 1023, and a long result hold-off");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
